// ===== src/lobm_pkg.sv =====
// Shared types and codes for the limit order book matcher.
`timescale 1ns / 1ps
package lobm_pkg;

   localparam int ID_W    = 16;
   localparam int QTY_W   = 16;
   localparam int PRICE_W = 8;
   localparam int TRADE_W = 6;

   // Record kinds
   localparam logic KIND_TRADE = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   // Done status codes
   localparam logic [1:0] STAT_FILLED = 2'd0;
   localparam logic [1:0] STAT_RESTED = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;
   localparam logic [1:0] STAT_LIMIT  = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]    order_id;
      logic               side;
      logic [PRICE_W-1:0] price_level;
      logic [QTY_W-1:0]   order_qty;
   } req_type;

   typedef struct packed {
      logic               record_kind;
      logic [ID_W-1:0]    incoming_ref;
      logic [ID_W-1:0]    resting_ref;
      logic [PRICE_W-1:0] trade_price;
      logic [QTY_W-1:0]   trade_quantity;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

endpackage

// ===== src/lobm_ram.sv =====
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module lobm_ram #(
   parameter int ADDR_W = 9,
   parameter int DATA_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/limit_order_book_matcher.sv =====
// Top level: price-time priority order book matcher with a shared sequencer.
// Order flow: a zero-quantity order goes straight to its done record; otherwise the
// sequencer reads each level visited, reads and reports each fill, then closes, first
// trying to rest any remainder at its limit level, and waits on result back-pressure.
// Orders are handled one at a time: no request is taken until the last done record is issued.
// Reset: a clearing pass over every level-table address zeroes heads and counts;
// no request is taken until it finishes.
`timescale 1ns / 1ps
module limit_order_book_matcher #(
   parameter int PRICE_LEVELS = 256,
   parameter int LEVEL_DEPTH  = 16,
   parameter int MAX_TRADES   = 63
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lobm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lobm_pkg::rsp_type rsp_data
);
   import lobm_pkg::*;

   localparam int LVL_W  = $clog2(PRICE_LEVELS);
   localparam int HEAD_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
   localparam int META_W = HEAD_W + CNT_W;
   localparam int MA_W   = LVL_W + 1;
   localparam int OA_W   = LVL_W + HEAD_W + 1;
   localparam int ORD_W  = ID_W + QTY_W;
   localparam int POS_W  = CNT_W + 1;

   // Sequencer states
   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_MREAD = 4'd2;
   localparam logic [3:0] ST_MCHK  = 4'd3;
   localparam logic [3:0] ST_ORD   = 4'd4;
   localparam logic [3:0] ST_OFILL = 4'd5;
   localparam logic [3:0] ST_FINAL = 4'd6;
   localparam logic [3:0] ST_RREAD = 4'd7;
   localparam logic [3:0] ST_RCHK  = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0]         state_ff, state_in;
   logic [MA_W-1:0]    clr_ff, clr_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic               sell_ff, sell_in;
   logic [LVL_W-1:0]   lim_ff, lim_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic [QTY_W-1:0]   qty_ff, qty_in;
   logic [TRADE_W-1:0] n_ff, n_in;
   logic [HEAD_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [1:0]         stat_ff, stat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic              meta_we;
   logic [MA_W-1:0]   meta_waddr, meta_raddr;
   logic [META_W-1:0] meta_wdata, meta_rdata;
   logic              ord_we;
   logic [OA_W-1:0]   ord_waddr, ord_raddr;
   logic [ORD_W-1:0]  ord_wdata, ord_rdata;

   // Scratch values
   logic [31:0]        price32;
   logic [HEAD_W-1:0]  rd_head;
   logic [CNT_W-1:0]   rd_count;
   logic [QTY_W-1:0]   rest_q, fill_q, qty_left, rest_left;
   logic [TRADE_W-1:0] n_next;
   logic [HEAD_W-1:0]  head_nx;
   logic [CNT_W-1:0]   cnt_nx;
   logic [POS_W-1:0]   pos_sum;
   logic [HEAD_W-1:0]  pos;
   logic               out_free, at_lim;
   logic [LVL_W-1:0]   lvl_step;

   // Level table: {head, count} per side and level; ask side at address top bit 1
   lobm_ram #(.ADDR_W(MA_W), .DATA_W(META_W)) u_meta (
      .clock  (clock),
      .wr_en  (meta_we),
      .wr_addr(meta_waddr),
      .wr_data(meta_wdata),
      .rd_addr(meta_raddr),
      .rd_data(meta_rdata)
   );

   // Resting order store: {id, qty} per side, level and FIFO slot
   lobm_ram #(.ADDR_W(OA_W), .DATA_W(ORD_W)) u_orders (
      .clock  (clock),
      .wr_en  (ord_we),
      .wr_addr(ord_waddr),
      .wr_data(ord_wdata),
      .rd_addr(ord_raddr),
      .rd_data(ord_rdata)
   );

   assign rd_head  = meta_rdata[META_W-1:CNT_W];
   assign rd_count = meta_rdata[CNT_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign at_lim   = (lvl_ff == lim_ff);
   assign lvl_step = sell_ff ? (lvl_ff - LVL_W'(1)) : (lvl_ff + LVL_W'(1));
   assign price32  = 32'(req_data.price_level);

   // Fill arithmetic
   assign rest_q    = ord_rdata[QTY_W-1:0];
   assign fill_q    = (rest_q < qty_ff) ? rest_q : qty_ff;
   assign qty_left  = qty_ff - fill_q;
   assign rest_left = rest_q - fill_q;
   assign n_next    = n_ff + TRADE_W'(1);
   assign head_nx   = (head_ff == HEAD_W'(LEVEL_DEPTH - 1)) ? '0 : head_ff + HEAD_W'(1);
   assign cnt_nx    = count_ff - CNT_W'(1);

   // Tail slot for resting the remainder
   assign pos_sum = POS_W'(rd_head) + POS_W'(rd_count);
   assign pos     = (pos_sum >= POS_W'(LEVEL_DEPTH)) ?
                    HEAD_W'(pos_sum - POS_W'(LEVEL_DEPTH)) : HEAD_W'(pos_sum);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      id_in        = id_ff;
      sell_in      = sell_ff;
      lim_in       = lim_ff;
      lvl_in       = lvl_ff;
      qty_in       = qty_ff;
      n_in         = n_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      meta_we      = 1'b0;
      meta_waddr   = {!sell_ff, lvl_ff};
      meta_wdata   = {head_nx, cnt_nx};
      meta_raddr   = {!sell_ff, lvl_ff};
      ord_we       = 1'b0;
      ord_waddr    = {!sell_ff, lvl_ff, head_ff};
      ord_wdata    = {ord_rdata[ORD_W-1:QTY_W], rest_left};
      ord_raddr    = {!sell_ff, lvl_ff, head_ff};
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            meta_wdata = '0;
            clr_in     = clr_ff + MA_W'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               id_in   = req_data.order_id;
               sell_in = req_data.side;
               lim_in  = (price32 > 32'(PRICE_LEVELS - 1)) ?
                         LVL_W'(PRICE_LEVELS - 1) : LVL_W'(price32);
               lvl_in  = req_data.side ? LVL_W'(PRICE_LEVELS - 1) : '0;
               qty_in  = req_data.order_qty;
               n_in    = '0;
               state_in = (req_data.order_qty == '0) ? ST_FINAL : ST_MREAD;
            end
         end
         ST_MREAD: begin
            state_in = ST_MCHK;
         end
         ST_MCHK: begin
            head_in  = rd_head;
            count_in = rd_count;
            if (rd_count != '0) begin
               state_in = ST_ORD;
            end else if (at_lim) begin
               state_in = ST_FINAL;
            end else begin
               lvl_in   = lvl_step;
               state_in = ST_MREAD;
            end
         end
         ST_ORD: begin
            state_in = ST_OFILL;
         end
         ST_OFILL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{record_kind:    KIND_TRADE,
                                incoming_ref:   id_ff,
                                resting_ref:    ord_rdata[ORD_W-1:QTY_W],
                                trade_price:    PRICE_W'(lvl_ff),
                                trade_quantity: fill_q,
                                status:         STAT_FILLED,
                                last:           1'b0};
               ord_we = 1'b1;
               qty_in = qty_left;
               n_in   = n_next;
               if (rest_left == '0) begin
                  meta_we  = 1'b1;
                  head_in  = head_nx;
                  count_in = cnt_nx;
               end
               // Stop on empty order or trade limit, else next order, next level, or stop at the limit level
               if (qty_left == '0 || n_next >= TRADE_W'(MAX_TRADES)) begin
                  state_in = ST_FINAL;
               end else if (cnt_nx != '0) begin
                  state_in = ST_ORD;
               end else if (at_lim) begin
                  state_in = ST_FINAL;
               end else begin
                  lvl_in   = lvl_step;
                  state_in = ST_MREAD;
               end
            end
         end
         ST_FINAL: begin
            priority if (qty_ff == '0) begin
               stat_in  = STAT_FILLED;
               state_in = ST_DONE;
            end else if (n_ff >= TRADE_W'(MAX_TRADES)) begin
               stat_in  = STAT_LIMIT;
               state_in = ST_DONE;
            end else begin
               state_in = ST_RREAD;
            end
         end
         ST_RREAD: begin
            meta_raddr = {sell_ff, lim_ff};
            state_in   = ST_RCHK;
         end
         ST_RCHK: begin
            if (rd_count >= CNT_W'(LEVEL_DEPTH)) begin
               stat_in = STAT_FULL;
            end else begin
               ord_we     = 1'b1;
               ord_waddr  = {sell_ff, lim_ff, pos};
               ord_wdata  = {id_ff, qty_ff};
               meta_we    = 1'b1;
               meta_waddr = {sell_ff, lim_ff};
               meta_wdata = {rd_head, rd_count + CNT_W'(1)};
               stat_in    = STAT_RESTED;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{record_kind:    KIND_DONE,
                                incoming_ref:   id_ff,
                                resting_ref:    '0,
                                trade_price:    '0,
                                trade_quantity: qty_ff,
                                status:         stat_ff,
                                last:           1'b1};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      sell_ff     <= sell_in;
      lim_ff      <= lim_in;
      lvl_ff      <= lvl_in;
      qty_ff      <= qty_in;
      n_ff        <= n_in;
      head_ff     <= head_in;
      count_ff    <= count_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_trade_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.record_kind == KIND_TRADE) |-> rsp_data.trade_quantity != '0)
      else $error("trade record with zero quantity");

   a_last_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == rsp_data.record_kind))
      else $error("last flag disagrees with record kind");

   a_trade_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR && state_ff != ST_IDLE) |-> n_ff <= TRADE_W'(MAX_TRADES))
      else $error("fill count beyond trade limit");

   a_no_req_in_clear: assert property (@(posedge clock)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

endmodule
